@@ rtl/core/glst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glst_pkg: shared types and constants of the grid Laplacian stencil
// Transaction payloads, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package glst_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int OUT_W        = 27;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int FAST_SIZE_W  = 10;
    localparam int SLOW_SIZE_W  = 16;

    localparam int MAX_LINE_DEF = 512;

    localparam int FAST_SIZE_RST = 301;
    localparam int SLOW_SIZE_RST = 601;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJOINT   = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered_value;
        logic                    last_point;
    } t_out_item;

endpackage : glst_pkg
`default_nettype wire

@@ rtl/core/glst_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glst_ram: generic RAM, one write port, two registered read ports
// Read-first: a read at the address written in the same cycle returns old data.
// ----------------------------------------------------------------------------
module glst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule : glst_ram
`default_nettype wire

@@ rtl/core/grid_laplacian_stencil_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_laplacian_stencil_unit: streaming five-point graph Laplacian
// Raster-order samples in, one Laplacian per grid point out, one line behind.
// Two line RAMs (even and odd lines) hold the center and upper neighbors.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid, o_in_ready, i_in_data         | in
//  output   | o_out_valid, i_out_ready, o_out_data      | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
//  One transaction per cycle sustained while the output is not stalled; a
//  result passes through the registered RAM read and the output register.
//  Reset is synchronous; the line RAMs are not cleared and need no sweep.
//  An output stall holds the read stage and the output register; input
//  ready drops only while both hold a result.
// ----------------------------------------------------------------------------
module grid_laplacian_stencil_unit #(
    parameter int MAX_LINE = glst_pkg::MAX_LINE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire glst_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output glst_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [glst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [glst_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_LINE);
    localparam int SW     = glst_pkg::SAMPLE_W;
    localparam int OW     = glst_pkg::OUT_W;
    localparam int SLW    = glst_pkg::SLOW_SIZE_W;
    localparam int FSW    = glst_pkg::FAST_SIZE_W;
    localparam int FAST_RST_EFF = (glst_pkg::FAST_SIZE_RST > MAX_LINE) ?
                                  MAX_LINE : glst_pkg::FAST_SIZE_RST;
    localparam logic [IDX_W-1:0] FAST_MAX_RST = IDX_W'(FAST_RST_EFF - 1);
    localparam logic [SLW-1:0]   SLOW_MAX_RST = SLW'(glst_pkg::SLOW_SIZE_RST - 1);

    // sizes and stream position
    logic [IDX_W-1:0] r_fast_max, n_fast_max;
    logic [SLW-1:0]   r_slow_max, n_slow_max;
    logic [IDX_W-1:0] r_fast_idx, n_fast_idx;
    logic [SLW-1:0]   r_slow_idx, n_slow_idx;
    logic             r_in_done,  n_in_done;
    logic             r_out_done, n_out_done;

    logic             w_accept;
    logic             w_is_flush;
    logic             w_take_sample;
    logic             w_take_flush;
    logic             w_emit;
    logic             w_line_end;
    logic             w_adv;
    logic             w_restart;
    logic [FSW-1:0]   w_cfg_fast;
    logic [SLW-1:0]   w_cfg_slow;

    // read stage
    logic             r_s1_valid;
    logic             r_s1_left_ok;
    logic             r_s1_right_ok;
    logic             r_s1_up_ok;
    logic             r_s1_down_ok;
    logic             r_s1_mid_odd;
    logic             r_s1_last;
    logic [SW-1:0]    r_s1_down;
    logic [SW-1:0]    r_left;

    // output register
    logic                r_out_valid;
    glst_pkg::t_out_item r_out_data;

    // RAM ports
    logic [SW-1:0]    w_even_a, w_even_b, w_odd_a, w_odd_b;
    logic [IDX_W-1:0] w_addr_b;

    // stencil datapath
    logic [SW-1:0]          w_c, w_r, w_u;
    logic signed [OW-1:0]   w_cx, w_lx, w_rx, w_ux, w_dx;
    logic signed [OW-1:0]   w_t_left, w_t_right, w_t_up, w_t_down;
    logic signed [OW-1:0]   w_lap;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_adv;

    assign w_accept      = i_in_valid && o_in_ready;
    assign w_is_flush    = (i_in_data.cmd == glst_pkg::CMD_FLUSH);
    assign w_take_sample = w_accept && !w_is_flush && !r_in_done;
    assign w_take_flush  = w_accept && w_is_flush && r_in_done && !r_out_done;
    assign w_emit        = (w_take_sample && (r_slow_idx != '0)) || w_take_flush;
    assign w_line_end    = (r_fast_idx == r_fast_max);
    assign w_restart     = i_cfg_we && ((i_cfg_idx == glst_pkg::CFG_FAST_SIZE) ||
                                        (i_cfg_idx == glst_pkg::CFG_SLOW_SIZE));
    assign w_cfg_fast    = i_cfg_data[FSW-1:0];
    assign w_cfg_slow    = i_cfg_data[SLW-1:0];

    always_comb begin
        n_fast_max = r_fast_max;
        n_slow_max = r_slow_max;
        n_fast_idx = r_fast_idx;
        n_slow_idx = r_slow_idx;
        n_in_done  = r_in_done;
        n_out_done = r_out_done;
        if (w_restart) begin
            n_fast_idx = '0;
            n_slow_idx = '0;
            n_in_done  = 1'b0;
            n_out_done = 1'b0;
            if (i_cfg_idx == glst_pkg::CFG_FAST_SIZE) begin
                if (w_cfg_fast == '0) begin
                    n_fast_max = '0;
                end else if (32'(w_cfg_fast) > 32'(MAX_LINE)) begin
                    n_fast_max = IDX_W'(MAX_LINE - 1);
                end else begin
                    n_fast_max = IDX_W'(32'(w_cfg_fast) - 32'd1);
                end
            end else begin
                n_slow_max = (w_cfg_slow == '0) ? '0 : w_cfg_slow - SLW'(1);
            end
        end else if (w_take_sample) begin
            if (w_line_end) begin
                n_fast_idx = '0;
                n_slow_idx = r_slow_idx + SLW'(1);
                n_in_done  = (r_slow_idx == r_slow_max);
            end else begin
                n_fast_idx = r_fast_idx + IDX_W'(1);
            end
        end else if (w_take_flush) begin
            if (w_line_end) begin
                n_fast_idx = '0;
                n_out_done = 1'b1;
            end else begin
                n_fast_idx = r_fast_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_max <= FAST_MAX_RST;
            r_slow_max <= SLOW_MAX_RST;
            r_fast_idx <= '0;
            r_slow_idx <= '0;
            r_in_done  <= 1'b0;
            r_out_done <= 1'b0;
        end else begin
            r_fast_max <= n_fast_max;
            r_slow_max <= n_slow_max;
            r_fast_idx <= n_fast_idx;
            r_slow_idx <= n_slow_idx;
            r_in_done  <= n_in_done;
            r_out_done <= n_out_done;
        end
    end

    assign w_addr_b = r_fast_idx + IDX_W'(1);

    glst_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LINE)
    ) u_ram_even (
        .i_clk       (i_clk),
        .i_wr_en     (w_take_sample && !r_slow_idx[0]),
        .i_wr_addr   (r_fast_idx),
        .i_wr_data   (i_in_data.sample),
        .i_rd_en     (w_emit),
        .i_rd_addr_a (r_fast_idx),
        .i_rd_addr_b (w_addr_b),
        .o_rd_data_a (w_even_a),
        .o_rd_data_b (w_even_b)
    );

    glst_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LINE)
    ) u_ram_odd (
        .i_clk       (i_clk),
        .i_wr_en     (w_take_sample && r_slow_idx[0]),
        .i_wr_addr   (r_fast_idx),
        .i_wr_data   (i_in_data.sample),
        .i_rd_en     (w_emit),
        .i_rd_addr_a (r_fast_idx),
        .i_rd_addr_b (w_addr_b),
        .o_rd_data_a (w_odd_a),
        .o_rd_data_b (w_odd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_emit) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_left_ok  <= (r_fast_idx != '0);
            r_s1_right_ok <= !w_line_end;
            r_s1_down_ok  <= !w_is_flush;
            r_s1_down     <= i_in_data.sample;
            r_s1_last     <= w_is_flush && w_line_end;
            if (w_is_flush) begin
                r_s1_up_ok   <= (r_slow_max != '0);
                r_s1_mid_odd <= r_slow_max[0];
            end else begin
                r_s1_up_ok   <= (r_slow_idx != SLW'(1));
                r_s1_mid_odd <= !r_slow_idx[0];
            end
        end
        if (r_s1_valid && w_adv) begin
            r_left <= w_c;
        end
    end

    assign w_c = r_s1_mid_odd ? w_odd_a  : w_even_a;
    assign w_r = r_s1_mid_odd ? w_odd_b  : w_even_b;
    assign w_u = r_s1_mid_odd ? w_even_a : w_odd_a;

    assign w_cx = OW'(signed'(w_c));
    assign w_lx = OW'(signed'(r_left));
    assign w_rx = OW'(signed'(w_r));
    assign w_ux = OW'(signed'(w_u));
    assign w_dx = OW'(signed'(r_s1_down));

    assign w_t_left  = r_s1_left_ok  ? (w_cx - w_lx) : '0;
    assign w_t_right = r_s1_right_ok ? (w_cx - w_rx) : '0;
    assign w_t_up    = r_s1_up_ok    ? (w_cx - w_ux) : '0;
    assign w_t_down  = r_s1_down_ok  ? (w_cx - w_dx) : '0;
    assign w_lap     = (w_t_left + w_t_right) + (w_t_up + w_t_down);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_data.filtered_value <= w_lap;
            r_out_data.last_point     <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule : grid_laplacian_stencil_unit
`default_nettype wire

@@ rtl/core/glst_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glst_checker: port-level checks of the grid Laplacian stencil
// Watches the top-level ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
module glst_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire glst_pkg::t_out_item o_out_data
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transaction changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without an input transaction two cycles before");

endmodule : glst_checker

bind grid_laplacian_stencil_unit glst_checker u_glst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
